// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the matrix multiplier modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define SMM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define SMM_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- design/smm_pkg.sv -----
// ----------------------------------------------------------------------------
// Matrix multiplier package
// Widths, types and the tag that follows each multiply-accumulate step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smm_pkg;

	localparam int MAX_SIZE   = 8;
	localparam int DATA_WIDTH = 32;
	localparam int SIZE_W     = 4;
	localparam int IDX_W      = $clog2(MAX_SIZE);
	localparam int DEPTH      = MAX_SIZE * MAX_SIZE;
	localparam int ADDR_W     = $clog2(DEPTH);

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic [SIZE_W-1:0]            size_t;
	typedef logic [IDX_W-1:0]             idx_t;
	typedef logic [ADDR_W-1:0]            addr_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last_k;
		idx_t row;
		idx_t column;
		logic last;
	} tag_t;

endpackage

// ----- design/smm_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/smm_mac.sv -----
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Registered multiply, then accumulate; drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smm_mac (
	input  logic           clk,
	input  logic           arst_n,
	input  smm_pkg::data_t a,
	input  smm_pkg::data_t b,
	input  smm_pkg::tag_t  tag_s1,
	output logic           product_valid,
	output smm_pkg::data_t product_value,
	output smm_pkg::idx_t  row,
	output smm_pkg::idx_t  column,
	output logic           last,
	output logic           done
);
	import smm_pkg::*;
	`include "assert_macros.svh"

	logic [DATA_WIDTH-1:0]   full_prod;
	logic [DATA_WIDTH-1:0]   prod_s2;
	tag_t                    tag_s2;
	logic [DATA_WIDTH-1:0]   sum;
	logic [DATA_WIDTH-1:0]   acc_q;
	logic                    valid_q;
	data_t                   value_q;
	idx_t                    row_q;
	idx_t                    column_q;
	logic                    last_q;

	assign full_prod = a * b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= full_prod;
	end

	assign sum = tag_s2.first ? prod_s2 : acc_q + prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tag_s2.valid && tag_s2.last_k;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s2.valid) begin
			acc_q <= sum;
		end
		if (tag_s2.valid && tag_s2.last_k) begin
			value_q  <= data_t'(sum);
			row_q    <= tag_s2.row;
			column_q <= tag_s2.column;
			last_q   <= tag_s2.last;
		end
	end

	assign product_valid = valid_q;
	assign product_value = value_q;
	assign row           = row_q;
	assign column        = column_q;
	assign last          = valid_q && last_q;
	assign done          = valid_q && last_q;

	`SMM_ASSERT(a_result_from_step, valid_q |-> $past(tag_s2.valid && tag_s2.last_k), "result without a final step")
	`SMM_ASSERT(a_last_is_final_cell, (tag_s2.valid && tag_s2.last_k && tag_s2.last) |=> (valid_q && last_q), "final cell not marked last")
	`SMM_ASSERT(a_no_result_after_last, (valid_q && last_q) |=> !valid_q, "result after the last item")

endmodule

// ----- design/smm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Load and compute sequencer
// Steers loaded items into the stores and walks i, j, k for the product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  smm_pkg::size_t cfg_data,
	input  logic           done,
	output logic           a_we,
	output logic           b_we,
	output smm_pkg::addr_t waddr,
	output smm_pkg::addr_t a_raddr,
	output smm_pkg::addr_t b_raddr,
	output smm_pkg::tag_t  tag_s1
);
	import smm_pkg::*;
	`include "assert_macros.svh"

	logic  busy_q;
	logic  issue_q;
	logic  phase_q;
	addr_t idx_q;
	idx_t  n_m1_q;
	addr_t cells_m1_q;
	idx_t  i_q;
	idx_t  j_q;
	idx_t  k_q;
	logic  accept;
	logic  cfg_wr;
	logic  last_elem;
	idx_t  new_n_m1;
	size_t new_n;
	logic [2*SIZE_W-1:0] new_cells;
	size_t n;
	tag_t  tag_q;

	assign accept    = start && !busy_q;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign last_elem = idx_q == cells_m1_q;
	assign n         = size_t'(n_m1_q) + size_t'(1);

	always_comb begin
		if (cfg_data == '0) begin
			new_n_m1 = '0;
		end else if (cfg_data > size_t'(MAX_SIZE)) begin
			new_n_m1 = idx_t'(MAX_SIZE - 1);
		end else begin
			new_n_m1 = idx_t'(cfg_data - size_t'(1));
		end
		new_n     = size_t'(new_n_m1) + size_t'(1);
		new_cells = {{SIZE_W{1'b0}}, new_n} * {{SIZE_W{1'b0}}, new_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			issue_q    <= 1'b0;
			phase_q    <= 1'b0;
			idx_q      <= '0;
			n_m1_q     <= idx_t'(MAX_SIZE - 1);
			cells_m1_q <= addr_t'(DEPTH - 1);
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
		end else begin
			if (cfg_wr) begin
				n_m1_q     <= new_n_m1;
				cells_m1_q <= addr_t'(new_cells - {{SIZE_W{1'b0}}, size_t'(1)});
				idx_q      <= '0;
				phase_q    <= 1'b0;
			end else if (accept) begin
				if (last_elem) begin
					idx_q   <= '0;
					phase_q <= ~phase_q;
					if (phase_q) begin
						busy_q  <= 1'b1;
						issue_q <= 1'b1;
					end
				end else begin
					idx_q <= idx_q + addr_t'(1);
				end
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (issue_q) begin
				if (k_q == n_m1_q) begin
					k_q <= '0;
					if (j_q == n_m1_q) begin
						j_q <= '0;
						if (i_q == n_m1_q) begin
							i_q     <= '0;
							issue_q <= 1'b0;
						end else begin
							i_q <= i_q + idx_t'(1);
						end
					end else begin
						j_q <= j_q + idx_t'(1);
					end
				end else begin
					k_q <= k_q + idx_t'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else begin
			tag_q.valid  <= issue_q;
			tag_q.first  <= k_q == '0;
			tag_q.last_k <= k_q == n_m1_q;
			tag_q.row    <= i_q;
			tag_q.column <= j_q;
			tag_q.last   <= (i_q == n_m1_q) && (j_q == n_m1_q);
		end
	end

	assign a_raddr   = addr_t'(addr_t'(i_q) * addr_t'(n) + addr_t'(k_q));
	assign b_raddr   = addr_t'(addr_t'(k_q) * addr_t'(n) + addr_t'(j_q));
	assign waddr     = idx_q;
	assign a_we      = accept && !cfg_wr && !phase_q;
	assign b_we      = accept && !cfg_wr && phase_q;
	assign busy      = busy_q;
	assign cfg_ready = !busy_q && !start;
	assign tag_s1    = tag_q;

	`SMM_ASSERT(a_issue_while_busy, issue_q |-> busy_q, "product steps issued while not busy")
	`SMM_NEVER(a_no_load_in_compute, (a_we || b_we) && issue_q, "store write during product steps")
	`SMM_ASSERT(a_busy_after_b, (accept && phase_q && last_elem && !cfg_wr) |=> issue_q, "final item did not start product")

endmodule

// ----- design/square_matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// Square matrix multiplier
// Loads A then B of side n, then streams C = A * B row-major, modulo 2^32.
// ----------------------------------------------------------------------------
// channel   handshake               payload
// load      start, busy             element
// config    cfg_valid, cfg_ready    cfg_data (matrix size)
// result    product_valid (strobe)  product_value, row, column, last
//
// Each loaded item is taken while start is high and busy is low; busy stays low while A and B load.
// The item that completes B raises busy until the last result, one
// multiply-accumulate per cycle through the single shared multiplier.
// A result appears after each n multiply-accumulate steps and cannot be stalled by the receiver.
// The configuration channel is not ready while busy or start is high.
// Reset clears the load position and sets the size to eight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module square_matrix_multiply (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  smm_pkg::data_t element,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  smm_pkg::size_t cfg_data,
	output logic           product_valid,
	output smm_pkg::data_t product_value,
	output smm_pkg::idx_t  row,
	output smm_pkg::idx_t  column,
	output logic           last
);
	import smm_pkg::*;

	logic  a_we;
	logic  b_we;
	logic  done;
	addr_t waddr;
	addr_t a_raddr;
	addr_t b_raddr;
	data_t a_rdata;
	data_t b_rdata;
	tag_t  tag_s1;

	smm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.a_we      (a_we),
		.b_we      (b_we),
		.waddr     (waddr),
		.a_raddr   (a_raddr),
		.b_raddr   (b_raddr),
		.tag_s1    (tag_s1)
	);

	smm_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_left_store (
		.clk   (clk),
		.we    (a_we),
		.waddr (waddr),
		.wdata (element),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	smm_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_right_store (
		.clk   (clk),
		.we    (b_we),
		.waddr (waddr),
		.wdata (element),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	smm_mac u_mac (
		.clk           (clk),
		.arst_n        (arst_n),
		.a             (a_rdata),
		.b             (b_rdata),
		.tag_s1        (tag_s1),
		.product_valid (product_valid),
		.product_value (product_value),
		.row           (row),
		.column        (column),
		.last          (last),
		.done          (done)
	);

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square matrix multiplier testbench
// Loads A and B through the start/busy channel and sets the side length
// through the configuration channel. An internal model computes each product
// matrix, and every strobed result is compared field by field with the oldest
// expected element. Directed cases cover the reset size, extreme elements,
// the size limits and a size change part way through loading. Random
// passes with random sizes and content follow, with occasional broken passes.
// ----------------------------------------------------------------------------

module testbench;
	import smm_pkg::*;

	typedef struct {
		data_t value;
		idx_t  row;
		idx_t  column;
		logic  last;
	} product_t;

	localparam data_t MOST_NEGATIVE = data_t'(32'h8000_0000);
	localparam data_t MOST_POSITIVE = data_t'(32'h7FFF_FFFF);

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	data_t element;
	logic  cfg_valid;
	logic  cfg_ready;
	size_t cfg_data;
	logic  product_valid;
	data_t product_value;
	idx_t  row;
	idx_t  column;
	logic  last;

	data_t    a_store [DEPTH];
	data_t    b_store [DEPTH];
	int       loaded = 0;
	size_t    size_reg = size_t'(MAX_SIZE);
	product_t expected_products [$];
	product_t oldest;
	int       errors = 0;
	int       items_sent = 0;
	int       products_checked = 0;
	int       size_writes = 0;

	square_matrix_multiply dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.element       (element),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.product_valid (product_valid),
		.product_value (product_value),
		.row           (row),
		.column        (column),
		.last          (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic int side_length();
		int n;
		n = int'(size_reg);
		if (n < 1) n = 1;
		if (n > MAX_SIZE) n = MAX_SIZE;
		return n;
	endfunction

	function automatic void predict_load(data_t v);
		int       n;
		int       cells;
		data_t    acc;
		product_t p;
		n = side_length();
		cells = n * n;
		if (loaded < cells) begin
			a_store[loaded] = v;
			loaded++;
		end else begin
			b_store[loaded - cells] = v;
			loaded++;
			if (loaded == 2 * cells) begin
				loaded = 0;
				for (int i = 0; i < n; i++) begin
					for (int j = 0; j < n; j++) begin
						acc = '0;
						for (int k = 0; k < n; k++) begin
							acc = acc + a_store[i * n + k] * b_store[k * n + j];
						end
						p.value  = acc;
						p.row    = idx_t'(i);
						p.column = idx_t'(j);
						p.last   = (i == n - 1) && (j == n - 1);
						expected_products.push_back(p);
					end
				end
			end
		end
	endfunction

	function automatic data_t rand_element();
		case ($urandom_range(0, 3))
			0: begin
				return data_t'(int'($urandom_range(0, 16)) - 8);
			end
			1: begin
				case ($urandom_range(0, 3))
					0: return MOST_NEGATIVE;
					1: return MOST_POSITIVE;
					2: return data_t'(0);
					default: return data_t'(-1);
				endcase
			end
			default: begin
				return data_t'($urandom);
			end
		endcase
	endfunction

	task automatic send_element(data_t v);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		element <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_load(v);
		items_sent++;
	endtask

	task automatic settle();
		start <= 1'b0;
		while (expected_products.size() != 0) @(posedge clk);
		repeat (side_length() ** 3 + 8) @(posedge clk);
	endtask

	task automatic write_size(size_t v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		size_reg = v;
		loaded = 0;
		size_writes++;
	endtask

	task automatic test_reset_size();
		repeat (2 * MAX_SIZE * MAX_SIZE) send_element(rand_element());
	endtask

	task automatic test_single_extremes();
		write_size(size_t'(1));
		send_element(MOST_NEGATIVE);
		send_element(MOST_NEGATIVE);
		send_element(MOST_POSITIVE);
		send_element(MOST_POSITIVE);
		send_element(MOST_NEGATIVE);
		send_element(MOST_POSITIVE);
		send_element(MOST_POSITIVE);
		send_element(data_t'(-1));
		send_element(data_t'(0));
		send_element(MOST_NEGATIVE);
	endtask

	task automatic test_size_zero();
		write_size(size_t'(0));
		send_element(data_t'(-3));
		send_element(data_t'(7));
	endtask

	task automatic test_two_by_two();
		write_size(size_t'(2));
		send_element(MOST_POSITIVE);
		send_element(MOST_NEGATIVE);
		send_element(data_t'(-1));
		send_element(data_t'(1));
		send_element(MOST_POSITIVE);
		send_element(data_t'(2));
		send_element(MOST_NEGATIVE);
		send_element(data_t'(-1));
	endtask

	// A size write drops the partial load, so the next item starts a new A.
	task automatic test_size_change_mid_pass();
		write_size(size_t'(2));
		repeat (3) send_element(rand_element());
		write_size(size_t'(1));
		send_element(rand_element());
		send_element(rand_element());
	endtask

	task automatic test_size_too_large();
		write_size(size_t'(15));
		repeat (2 * MAX_SIZE * MAX_SIZE) send_element(rand_element());
	endtask

	task automatic test_random_passes();
		int    count;
		int    r;
		int    cells;
		int    passes;
		int    k;
		size_t v;
		count = 0;
		while (count < 40) begin
			r = $urandom_range(0, 15);
			if (r < 10) v = size_t'($urandom_range(1, 4));
			else if (r == 10) v = size_t'(0);
			else if (r < 14) v = size_t'($urandom_range(5, 7));
			else if (r == 14) v = size_t'(8);
			else v = size_t'($urandom_range(9, 15));
			write_size(v);
			cells = side_length() ** 2;
			passes = (cells > 16) ? 1 : $urandom_range(1, 3);
			for (int p = 0; p < passes; p++) begin
				if ($urandom_range(0, 9) == 0) k = $urandom_range(1, 2 * cells - 1);
				else k = 2 * cells;
				repeat (k) send_element(rand_element());
				count += k;
				if (k < 2 * cells) break;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && product_valid) begin
			products_checked++;
			if (expected_products.size() == 0) begin
				$display("%0t: unexpected product, expected none, actual %0d at %0d,%0d",
					$time, product_value, row, column);
				errors++;
			end else begin
				oldest = expected_products.pop_front();
				if (product_value !== oldest.value) begin
					$display("%0t: product_value expected %0d actual %0d",
						$time, oldest.value, product_value);
					errors++;
				end
				if (row !== oldest.row) begin
					$display("%0t: row expected %0d actual %0d", $time, oldest.row, row);
					errors++;
				end
				if (column !== oldest.column) begin
					$display("%0t: column expected %0d actual %0d",
						$time, oldest.column, column);
					errors++;
				end
				if (last !== oldest.last) begin
					$display("%0t: last expected %0b actual %0b", $time, oldest.last, last);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		element   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size();
		test_single_extremes();
		test_size_zero();
		test_two_by_two();
		test_size_change_mid_pass();
		test_size_too_large();
		test_random_passes();
		start <= 1'b0;
		while (expected_products.size() != 0) @(posedge clk);
		repeat (side_length() ** 3 + 8) @(posedge clk);
		$display("Run loaded %0d items and checked %0d products over %0d size settings.",
			items_sent, products_checked, size_writes);
		$display("Sizes from zero to fifteen, extreme elements and dropped passes were covered.");
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
